// File: design/servo_bus_status_packet_checker_macros.svh
// Assertion macros for the status packet checker
`ifndef SERVO_BUS_STATUS_PACKET_CHECKER_MACROS_SVH
`define SERVO_BUS_STATUS_PACKET_CHECKER_MACROS_SVH

// same-cycle implication
`define SBSPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbspc: assertion failed");

// next-cycle implication
`define SBSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbspc: assertion failed");

`endif

// File: design/sbspc_pkg.sv
`default_nettype none

package sbspc_pkg;

	localparam int unsigned RX_CAPACITY_DEF = 31;
	localparam int unsigned MIN_PACKET      = 11;
	localparam int unsigned LSW             = 17;

	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [7:0]  HDR_BYTE0    = 8'hFF;
	localparam logic [7:0]  HDR_BYTE1    = 8'hFF;
	localparam logic [7:0]  HDR_BYTE2    = 8'hFD;
	localparam logic [7:0]  HDR_BYTE3    = 8'h00;
	localparam logic [7:0]  INSTR_STATUS = 8'h55;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_NO_DATA = 4'd1;
	localparam logic [3:0] ST_SHORT   = 4'd2;
	localparam logic [3:0] ST_HEADER  = 4'd3;
	localparam logic [3:0] ST_LENGTH  = 4'd4;
	localparam logic [3:0] ST_CRC     = 4'd5;
	localparam logic [3:0] ST_ID      = 4'd6;
	localparam logic [3:0] ST_INSTR   = 4'd7;
	localparam logic [3:0] ST_DEV_ERR = 4'd8;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] dev_id;
		logic       window_end;
	} item_word_t;

	typedef struct packed {
		logic [3:0] status;
		logic [7:0] param_byte;
		logic       param_valid;
		logic [4:0] param_count;
		logic [7:0] device_error;
		logic       last;
	} result_word_t;

endpackage

`default_nettype wire

// File: design/servo_bus_status_packet_checker.sv
// channel  | valid        | stall        | word
// item     | item_valid   | item_stall   | item   (rx_byte, dev_id, window_end)
// result   | result_valid | result_stall | result (status .. last)
//
// A byte word is accepted in S_IDLE, then shifted through the bit-serial CRC shifter in S_CRC.
// A verdict is judged in S_JUDGE, then each parameter is read from the store and loaded.
// A window end after a verdict clears the verdict in S_IDLE. item_stall is high while busy.
// arst_n clears control state; the frame store is not cleared.
// result_stall holds the output register; a verdict waits on it before loading its next word.
`default_nettype none
`include "servo_bus_status_packet_checker_macros.svh"

module servo_bus_status_packet_checker import sbspc_pkg::*; #(
	parameter int unsigned RX_CAPACITY = RX_CAPACITY_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire item_word_t   item,
	output logic              result_valid,
	input  wire logic         result_stall,
	output result_word_t      result
);

	localparam int unsigned CW = $clog2(RX_CAPACITY + 1);
	localparam int unsigned AW = $clog2(RX_CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CRC   = 3'd1;
	localparam logic [2:0] S_JUDGE = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] byte_cnt_q;
	logic [15:0]   crc_q;
	logic [2:0]    bit_cnt_q;
	logic          verdict_q;
	logic          wend_q;
	logic [7:0]    tid_q;
	logic [CW-1:0] par_idx_q;
	logic          res_valid_q;

	logic [7:0]    sh_q;
	logic          crc_en_q;
	logic          hdr_ok_q;
	logic [7:0]    len_l_q;
	logic [7:0]    len_h_q;
	logic [7:0]    id_q;
	logic [7:0]    instr_q;
	logic [7:0]    err_q;
	logic [7:0]    rxcrc_l_q;
	logic [7:0]    rxcrc_h_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    store_q [RX_CAPACITY];
	result_word_t  res_q;

	logic           acc;
	logic           take_byte;
	logic           out_free;
	logic [15:0]    plen;
	logic [LSW-1:0] total;
	logic [CW-1:0]  pc;
	logic [3:0]     status_c;
	logic           done_c;
	logic           emit_c;
	logic           last_c;
	logic           load_single;
	logic           load_par;
	logic           fb;
	logic [AW-1:0]  rd_addr;

	assign acc        = item_valid && !item_stall;
	assign take_byte  = acc && !item.window_end && !verdict_q &&
		(byte_cnt_q < CW'(RX_CAPACITY));
	assign out_free   = !res_valid_q || !result_stall;
	assign plen       = {len_h_q, len_l_q};
	assign total      = LSW'(plen) + LSW'(7);
	assign pc         = CW'(plen - 16'd4);
	assign last_c     = (par_idx_q + CW'(1)) == pc;
	assign emit_c     = (status_c == ST_OK) && (pc != '0);
	assign load_single = (state_q == S_JUDGE) && !emit_c && out_free;
	assign load_par    = (state_q == S_LOAD) && out_free;
	assign fb         = crc_q[15] ^ sh_q[7];
	assign rd_addr    = AW'(9) + par_idx_q[AW-1:0];
	assign done_c     = (byte_cnt_q == CW'(RX_CAPACITY)) ||
		((byte_cnt_q >= CW'(MIN_PACKET)) && (LSW'(byte_cnt_q) >= total));

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		if (byte_cnt_q == '0) begin
			status_c = ST_NO_DATA;
		end else if (byte_cnt_q < CW'(MIN_PACKET)) begin
			status_c = ST_SHORT;
		end else if (!hdr_ok_q) begin
			status_c = ST_HEADER;
		end else if (LSW'(byte_cnt_q) < total) begin
			status_c = ST_SHORT;
		end else if (plen < 16'd4) begin
			status_c = ST_LENGTH;
		end else if ({rxcrc_h_q, rxcrc_l_q} != crc_q) begin
			status_c = ST_CRC;
		end else if (id_q != tid_q) begin
			status_c = ST_ID;
		end else if (instr_q != INSTR_STATUS) begin
			status_c = ST_INSTR;
		end else if (err_q != 8'h00) begin
			status_c = ST_DEV_ERR;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			byte_cnt_q  <= '0;
			crc_q       <= '0;
			bit_cnt_q   <= '0;
			verdict_q   <= 1'b0;
			wend_q      <= 1'b0;
			tid_q       <= '0;
			par_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_single || load_par) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc && item.window_end) begin
						if (verdict_q) begin
							byte_cnt_q <= '0;
							crc_q      <= '0;
							verdict_q  <= 1'b0;
						end else begin
							wend_q  <= 1'b1;
							state_q <= S_JUDGE;
						end
					end else if (take_byte) begin
						if (byte_cnt_q == '0) begin
							tid_q <= item.dev_id;
						end
						byte_cnt_q <= byte_cnt_q + CW'(1);
						bit_cnt_q  <= '0;
						state_q    <= S_CRC;
					end
				end
				S_CRC: begin
					if (crc_en_q) begin
						crc_q <= {crc_q[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
					end
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						state_q <= done_c ? S_JUDGE : S_IDLE;
					end
				end
				S_JUDGE: begin
					if (emit_c) begin
						par_idx_q <= '0;
						state_q   <= S_READ;
					end else if (out_free) begin
						state_q <= S_IDLE;
						if (wend_q) begin
							byte_cnt_q <= '0;
							crc_q      <= '0;
							verdict_q  <= 1'b0;
							wend_q     <= 1'b0;
						end else begin
							verdict_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						if (last_c) begin
							state_q <= S_IDLE;
							if (wend_q) begin
								byte_cnt_q <= '0;
								crc_q      <= '0;
								verdict_q  <= 1'b0;
								wend_q     <= 1'b0;
							end else begin
								verdict_q <= 1'b1;
							end
						end else begin
							par_idx_q <= par_idx_q + CW'(1);
							state_q   <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte) begin
			store_q[byte_cnt_q[AW-1:0]] <= item.rx_byte;
			sh_q     <= item.rx_byte;
			crc_en_q <= (byte_cnt_q < CW'(7)) ||
				(LSW'(byte_cnt_q) < (LSW'(plen) + LSW'(5)));
			if (byte_cnt_q == CW'(0)) begin
				hdr_ok_q <= (item.rx_byte == HDR_BYTE0);
			end
			if (byte_cnt_q == CW'(1)) begin
				hdr_ok_q <= hdr_ok_q && (item.rx_byte == HDR_BYTE1);
			end
			if (byte_cnt_q == CW'(2)) begin
				hdr_ok_q <= hdr_ok_q && (item.rx_byte == HDR_BYTE2);
			end
			if (byte_cnt_q == CW'(3)) begin
				hdr_ok_q <= hdr_ok_q && (item.rx_byte == HDR_BYTE3);
			end
			if (byte_cnt_q == CW'(4)) begin
				id_q <= item.rx_byte;
			end
			if (byte_cnt_q == CW'(5)) begin
				len_l_q <= item.rx_byte;
			end
			if (byte_cnt_q == CW'(6)) begin
				len_h_q <= item.rx_byte;
			end
			if (byte_cnt_q == CW'(7)) begin
				instr_q <= item.rx_byte;
			end
			if (byte_cnt_q == CW'(8)) begin
				err_q <= item.rx_byte;
			end
			if ((byte_cnt_q >= CW'(7)) &&
				(LSW'(byte_cnt_q) == (LSW'(plen) + LSW'(5)))) begin
				rxcrc_l_q <= item.rx_byte;
			end
			if ((byte_cnt_q >= CW'(7)) &&
				(LSW'(byte_cnt_q) == (LSW'(plen) + LSW'(6)))) begin
				rxcrc_h_q <= item.rx_byte;
			end
		end else if (state_q == S_CRC) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end

		if (state_q == S_READ) begin
			rd_data_q <= store_q[rd_addr];
		end

		if (load_single) begin
			res_q.status       <= status_c;
			res_q.param_byte   <= 8'h00;
			res_q.param_valid  <= 1'b0;
			res_q.param_count  <= 5'd0;
			res_q.device_error <= (status_c == ST_DEV_ERR) ? err_q : 8'h00;
			res_q.last         <= 1'b1;
		end else if (load_par) begin
			res_q.status       <= ST_OK;
			res_q.param_byte   <= rd_data_q;
			res_q.param_valid  <= 1'b1;
			res_q.param_count  <= 5'(pc);
			res_q.device_error <= 8'h00;
			res_q.last         <= last_c;
		end
	end

	`SBSPC_ASSERT_NOW(a_par_only_ok, clk, arst_n,
		result_valid && result.param_valid, result.status == ST_OK)
	`SBSPC_ASSERT_NOW(a_par_count_nz, clk, arst_n,
		result_valid && result.param_valid, result.param_count != 5'd0)
	`SBSPC_ASSERT_NOW(a_cnt_cap, clk, arst_n,
		1'b1, byte_cnt_q <= CW'(RX_CAPACITY))
	`SBSPC_ASSERT_NEXT(a_wend_clears, clk, arst_n,
		acc && item.window_end && verdict_q, byte_cnt_q == '0 && !verdict_q)

endmodule

`default_nettype wire
